[hdl/pclr_pkg.sv]
// Shared types, constants and helpers for the press counter with lockout report.
package pclr_pkg;

  localparam logic [15:0] LOCKOUT_RESET = 16'(5000 / 8);
  localparam logic [7:0]  CMD_REPORT    = 8'h72;  // 'r'
  localparam logic [7:0]  CMD_CLEAR     = 8'h63;  // 'c'
  localparam logic [7:0]  CHAR_CR       = 8'h0d;
  localparam logic [7:0]  CHAR_LF       = 8'h0a;
  localparam logic [7:0]  CHAR_SPACE    = 8'h20;
  localparam logic [7:0]  CHAR_ZERO     = 8'h30;
  localparam logic [7:0]  CHAR_HEX_BASE = 8'h57;  // 'a' - 10
  localparam logic [3:0]  NIBBLE_MASK   = 4'hf;
  localparam logic [2:0]  POS_SPACE     = 3'd4;

  localparam logic MODE_POLL    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;
  localparam logic KIND_POLL    = 1'b0;
  localparam logic KIND_CHAR    = 1'b1;

  typedef enum logic [1:0] {
    RPT_IDLE,
    RPT_DIGIT,
    RPT_CR,
    RPT_LF
  } rpt_state_t;

  // control from the top level into the report unit
  typedef struct packed {
    logic start;
    logic clear;
    logic step;
  } rpt_ctl_t;

  // one report character handed back to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } rpt_char_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [3:0] n;
    n = v & NIBBLE_MASK;
    if (n < 4'd10) hex_char = CHAR_ZERO + {4'd0, n};
    else           hex_char = CHAR_HEX_BASE + {4'd0, n};
  endfunction

endpackage

[hdl/pclr_lane.sv]
// One line lane: lockout flag, event timestamp and expiry compare.
module pclr_lane
  import pclr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        poll,
  input  logic        line_low,
  input  logic [15:0] time_now,
  input  logic [15:0] lockout_ticks,
  output logic        event_hit,
  output logic        expired
);

  logic        flag_r, flag_nxt;
  logic [15:0] time_r, time_nxt;
  logic        flag_mid;
  logic [15:0] age;

  // events first, then expiry against the updated state
  always_comb begin
    event_hit = line_low && !flag_r;
    flag_mid  = flag_r || event_hit;
    time_nxt  = event_hit ? time_now : time_r;
    age       = time_now - time_nxt;
    expired   = flag_mid && (age > lockout_ticks);
    flag_nxt  = flag_mid && !expired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (poll) begin
      flag_r <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (poll) begin
      time_r <= time_nxt;
    end
  end

endmodule

[hdl/pclr_report.sv]
// Press counters and the sequencer that spells them out as hex text.
module pclr_report
  import pclr_pkg::*;
#(
  parameter int BUTTONS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpt_ctl_t           ctl,
  input  logic [BUTTONS-1:0] press_inc,
  output logic               active,
  output rpt_char_t          char_out
);

  localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [BW-1:0] BTN_LAST = BW'(BUTTONS - 1);

  rpt_state_t    state_r, state_nxt;
  logic [BW-1:0] btn_r, btn_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic [15:0]   count_r [BUTTONS];
  logic [15:0]   count_sel;
  logic [3:0]    nibble;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUTTONS; b++) count_r[b] <= '0;
    end else if (ctl.clear) begin
      for (int b = 0; b < BUTTONS; b++) count_r[b] <= '0;
    end else begin
      for (int b = 0; b < BUTTONS; b++) begin
        if (press_inc[b]) count_r[b] <= count_r[b] + 16'd1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    btn_nxt   = btn_r;
    pos_nxt   = pos_r;
    case (state_r)
      RPT_IDLE: begin
        if (ctl.start) begin
          state_nxt = RPT_DIGIT;
          btn_nxt   = '0;
          pos_nxt   = '0;
        end
      end
      RPT_DIGIT: begin
        if (ctl.step) begin
          if (pos_r == POS_SPACE) begin
            pos_nxt = '0;
            if (btn_r == BTN_LAST) state_nxt = RPT_CR;
            else                   btn_nxt   = btn_r + BW'(1);
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end
      end
      RPT_CR: begin
        if (ctl.step) state_nxt = RPT_LF;
      end
      RPT_LF: begin
        if (ctl.step) state_nxt = RPT_IDLE;
      end
      default: state_nxt = RPT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RPT_IDLE;
      btn_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      btn_r   <= btn_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // outputs
  always_comb begin
    count_sel      = count_r[btn_r];
    // pos 0 picks bits 15:12, pos 3 bits 3:0
    nibble         = 4'(count_sel >> {~pos_r[1:0], 2'b00});
    active         = (state_r != RPT_IDLE);
    char_out.valid = active && ctl.step;
    char_out.last  = (state_r == RPT_LF);
    case (state_r)
      RPT_DIGIT: char_out.ch = (pos_r == POS_SPACE) ? CHAR_SPACE : hex_char(nibble);
      RPT_CR:    char_out.ch = CHAR_CR;
      RPT_LF:    char_out.ch = CHAR_LF;
      default:   char_out.ch = '0;
    endcase
  end

endmodule

[hdl/press_counter_with_lockout_report_top.sv]
// Top level: per-line lanes, merge of lane results, report unit and output register.
//
//   channel | ports                                          | direction
//   in      | in_valid/in_ready, mode, pin_levels, time, cmd | consumed
//   out     | out_valid/out_ready, kind, mask, pulse, char   | produced
//   cfg     | cfg_wr_en, cfg_wr_data (lockout_ticks)         | written
//
// A poll is handled in the accept cycle by all lanes at once; its status
// lands in the output register, where it waits for the out handshake.
// A report emits 5*BUTTONS+2 characters, one per cycle while out_ready holds;
// the input is held off until the last character is loaded.
// Reset is synchronous, active low; lockout_ticks returns to 625.
// A stalled output holds its register; input is taken once the slot frees.
module press_counter_with_lockout_report_top
  import pclr_pkg::*;
#(
  parameter int BUTTONS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_pin_levels,
  input  logic [15:0] in_time_now,
  input  logic [7:0]  in_command_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_event_mask,
  output logic        out_clear_pulse,
  output logic [7:0]  out_report_char,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int LINES = 2 * BUTTONS;

  logic [15:0]        ticks_r;
  logic               out_valid_r, out_kind_r, out_clear_pulse_r, out_last_r;
  logic [7:0]         out_event_mask_r, out_report_char_r;
  logic               slot_free, accept, poll;
  logic [LINES-1:0]   ev, exp_v;
  logic [7:0]         mask8;
  logic [BUTTONS-1:0] press_inc;
  logic               rpt_active;
  rpt_ctl_t           rctl;
  rpt_char_t          rchar;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= LOCKOUT_RESET;
    end else if (cfg_wr_en) begin
      ticks_r <= cfg_wr_data;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !rpt_active && slot_free;
  assign accept    = in_valid && in_ready;
  assign poll      = accept && (in_mode == MODE_POLL);

  genvar g;
  generate
    for (g = 0; g < LINES; g++) begin : g_lane
      logic low;
      if (g < 8) begin : g_pin
        assign low = !in_pin_levels[g];
      end else begin : g_none
        assign low = 1'b0;
      end
      pclr_lane u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll         (poll),
        .line_low     (low),
        .time_now     (in_time_now),
        .lockout_ticks(ticks_r),
        .event_hit    (ev[g]),
        .expired      (exp_v[g])
      );
    end
    for (g = 0; g < 8; g++) begin : g_mask
      if (g < LINES) begin : g_on
        assign mask8[g] = ev[g];
      end else begin : g_off
        assign mask8[g] = 1'b0;
      end
    end
    for (g = 0; g < BUTTONS; g++) begin : g_inc
      assign press_inc[g] = poll && ev[2*g];
    end
  endgenerate

  always_comb begin
    rctl.start = accept && (in_mode == MODE_COMMAND) && (in_command_byte == CMD_REPORT);
    rctl.clear = accept && (in_mode == MODE_COMMAND) && (in_command_byte == CMD_CLEAR);
    rctl.step  = slot_free;
  end

  pclr_report #(.BUTTONS(BUTTONS)) u_report (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rctl),
    .press_inc(press_inc),
    .active   (rpt_active),
    .char_out (rchar)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (poll || rchar.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll) begin
      out_kind_r        <= KIND_POLL;
      out_event_mask_r  <= mask8;
      out_clear_pulse_r <= |exp_v;
      out_report_char_r <= '0;
      out_last_r        <= 1'b1;
    end else if (rchar.valid) begin
      out_kind_r        <= KIND_CHAR;
      out_event_mask_r  <= '0;
      out_clear_pulse_r <= 1'b0;
      out_report_char_r <= rchar.ch;
      out_last_r        <= rchar.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_event_mask  = out_event_mask_r;
  assign out_clear_pulse = out_clear_pulse_r;
  assign out_report_char = out_report_char_r;
  assign out_last        = out_last_r;

endmodule

[verif/tb.sv]
// Testbench for the press counter with lockout report: directed and random stimulus, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import pclr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_CYCLES = 8;
  localparam int TAIL_CYCLES = 30;

  typedef struct packed {
    logic       kind;
    logic [7:0] mask;
    logic       pulse;
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  class press_scoreboard;
    logic [15:0] lockout_ticks;
    bit          locked[8];
    logic [15:0] stamp[8];
    logic [15:0] presses[4];
    out_beat_t   due[$];
    int          errors;

    function new();
      lockout_ticks = LOCKOUT_RESET;
      foreach (locked[i]) begin
        locked[i] = 1'b0;
        stamp[i] = '0;
      end
      foreach (presses[i]) presses[i] = '0;
      errors = 0;
    endfunction

    function logic [7:0] nibble_char(logic [3:0] n);
      return {4'd0, n} + ((n < 4'd10) ? CHAR_ZERO : CHAR_HEX_BASE);
    endfunction

    // Works out the results that one accepted input transaction must cause.
    function void note_input(logic mode, logic [7:0] pins, logic [15:0] now,
                             logic [7:0] cmd);
      logic [7:0]  fired;
      logic        expired;
      logic [15:0] age;
      if (mode == MODE_POLL) begin
        fired = '0;
        expired = 1'b0;
        for (int i = 0; i < 8; i++) begin
          if (!pins[i] && !locked[i]) begin
            fired[i] = 1'b1;
            locked[i] = 1'b1;
            stamp[i] = now;
          end
        end
        // expiry sees the stamps just taken, so fresh locks never expire here
        for (int i = 0; i < 8; i++) begin
          age = now - stamp[i];
          if (locked[i] && age > lockout_ticks) begin
            locked[i] = 1'b0;
            expired = 1'b1;
          end
        end
        for (int btn = 0; btn < 4; btn++)
          if (fired[2*btn]) presses[btn]++;
        due.push_back('{KIND_POLL, fired, expired, 8'h00, 1'b1});
      end else if (cmd == CMD_REPORT) begin
        for (int btn = 0; btn < 4; btn++) begin
          for (int d = 3; d >= 0; d--)
            due.push_back('{KIND_CHAR, 8'h00, 1'b0, nibble_char(presses[btn][4*d +: 4]),
                            1'b0});
          due.push_back('{KIND_CHAR, 8'h00, 1'b0, CHAR_SPACE, 1'b0});
        end
        due.push_back('{KIND_CHAR, 8'h00, 1'b0, CHAR_CR, 1'b0});
        due.push_back('{KIND_CHAR, 8'h00, 1'b0, CHAR_LF, 1'b1});
      end else if (cmd == CMD_CLEAR) begin
        foreach (presses[i]) presses[i] = '0;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: kind %0d mask %02h pulse %0d char %02h last %0d",
                   got.kind, got.mask, got.pulse, got.ch, got.last);
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.mask !== want.mask || got.pulse !== want.pulse ||
          got.ch !== want.ch || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp kind %0d mask %02h pulse %0d char %02h last %0d, got kind %0d mask %02h pulse %0d char %02h last %0d",
                   want.kind, want.mask, want.pulse, want.ch, want.last,
                   got.kind, got.mask, got.pulse, got.ch, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_POLL;
  logic [7:0]  in_pin_levels = 8'hff;
  logic [15:0] in_time_now = '0;
  logic [7:0]  in_command_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_event_mask;
  logic        out_clear_pulse;
  logic [7:0]  out_report_char;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  press_scoreboard sb;
  out_beat_t       seen;
  int              send_idle = 33;
  int              recv_idle = 72;
  int              cycle_count = 0;
  logic [15:0]     poll_clock = '0;

  press_counter_with_lockout_report_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_pin_levels   (in_pin_levels),
    .in_time_now     (in_time_now),
    .in_command_byte (in_command_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_event_mask  (out_event_mask),
    .out_clear_pulse (out_clear_pulse),
    .out_report_char (out_report_char),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = {out_kind, out_event_mask, out_clear_pulse, out_report_char, out_last};
      sb.check_result(seen);
    end
  end

  // valid stays high between back-to-back transactions; it only drops for a gap
  task push_item(input logic mode, input logic [7:0] pins, input logic [15:0] now,
                 input logic [7:0] cmd);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_pin_levels <= pins;
    in_time_now <= now;
    in_command_byte <= cmd;
    do @(posedge clk); while (!in_ready);
    sb.note_input(mode, pins, now, cmd);
  endtask

  task poll(input logic [7:0] pins, input logic [15:0] now);
    push_item(MODE_POLL, pins, now, 8'($urandom));
  endtask

  task command(input logic [7:0] cmd);
    push_item(MODE_COMMAND, 8'($urandom), 16'($urandom), cmd);
  endtask

  // 'c' and ignored bytes give no result, so wait QUIET_CYCLES more after the due queue empties
  task wait_for_quiet();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task set_lockout(input logic [15:0] ticks);
    wait_for_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.lockout_ticks = ticks;
  endtask

  task random_items(input int count);
    int          pick;
    int          span;
    logic [7:0]  pins;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 9) command(CMD_REPORT);
      else if (pick < 12) command(CMD_CLEAR);
      else if (pick < 16) command(8'($urandom));
      else begin
        span = sb.lockout_ticks + sb.lockout_ticks / 2 + 2;
        if ($urandom_range(19) == 0) poll_clock = 16'($urandom);
        else poll_clock = poll_clock + 16'($urandom_range(span));
        case ($urandom_range(2))
          0: pins = 8'($urandom);
          1: pins = ~(8'h01 << $urandom_range(7));
          default: pins = 8'hff;
        endcase
        poll(pins, poll_clock);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset lockout of 625 ticks
    poll(8'hff, 16'd0);
    poll(8'h00, 16'd100);
    poll(8'h00, 16'd725);          // age equal to lockout: still held
    poll(8'hff, 16'd726);          // one past: all lines released
    poll(8'haa, 16'hfff0);         // press lines only
    poll(8'hff, 16'h0300);         // age across timer wrap
    command(CMD_REPORT);
    command(8'h00);
    command(8'hff);
    command(8'h52);
    command(CMD_CLEAR);
    command(CMD_REPORT);

    set_lockout(16'd0);
    poll(8'h00, 16'd500);
    poll(8'h00, 16'd500);          // zero age never expires
    poll(8'h00, 16'd501);          // held lines give no event, then expire
    poll(8'h00, 16'd501);

    set_lockout(16'hffff);
    poll(8'h00, 16'h1234);
    poll(8'hff, 16'd500);          // wrapped age, still not greater than the maximum lockout
    command(CMD_REPORT);

    poll_clock = 16'd600;
    set_lockout(16'd200);
    random_items(60);
    wait_for_quiet();
    random_items(70);

    send_idle = 72;
    recv_idle = 33;
    set_lockout(16'($urandom_range(4000)));
    random_items(130);

    send_idle = 0;
    recv_idle = 0;
    set_lockout(16'd1);
    random_items(120);

    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[press_counter_with_lockout_report_top.f]
hdl/pclr_pkg.sv
hdl/pclr_lane.sv
hdl/pclr_report.sv
hdl/press_counter_with_lockout_report_top.sv
verif/tb.sv
